/* hw/rtl/watt_pkg.sv */
`timescale 1ns / 1ps
package watt_pkg;
  localparam int TimerEntries = 8;
  localparam int TodW = 17;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET  = 2'd1,
    FUNC_DEL  = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_FIRE  = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_SCAN,
    ST_DONE,
    ST_SPLIT
  } state_t;

  localparam logic [1:0] REG_WORK_MODE = 2'd0;
  localparam logic [1:0] REG_DEV_MASK  = 2'd1;
  localparam logic [1:0] REG_DEV_NUM   = 2'd2;
endpackage

/* hw/rtl/watt_divider.sv */
`timescale 1ns / 1ps
// divider: splits a time of day into hours, minutes, seconds
// by repeated compare and subtract, one step per cycle
module watt_divider
  import watt_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [TodW-1:0] tod,
  output logic            done,
  output logic [4:0]      hrs,
  output logic [5:0]      mins,
  output logic [5:0]      secs
);
  logic [TodW-1:0] rem;
  logic [1:0]      phase;
  logic            run;

  // one subtract per cycle: hours first, then minutes
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        rem <= tod;
        hrs <= '0;
        mins <= '0;
        phase <= 2'd0;
      end else if (run) begin
        if (phase == 2'd0) begin
          if (rem >= TodW'(3600)) begin
            rem <= rem - TodW'(3600);
            hrs <= hrs + 5'd1;
          end else begin
            phase <= 2'd1;
          end
        end else begin
          if (rem >= TodW'(60)) begin
            rem <= rem - TodW'(60);
            mins <= mins + 6'd1;
          end else begin
            secs <= rem[5:0];
            run <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end
endmodule

/* hw/rtl/weekly_alarm_timer_table_top.sv */
`timescale 1ns / 1ps
// channel | signals                              | accepted when
// command | start, func, entry_index, fields     | start && !busy
// result  | valid, result_kind .. last           | every cycle valid is high
// config  | cfg_we, cfg_addr, cfg_data           | cfg_we high
// a tick keeps busy high through time compute, then each entry in turn through the
// shared compare unit, then completion; the scan is skipped if device mode is off
// set and delete keep busy high through time compute and completion; a read of an
// active entry runs the divider and keeps busy high until it has split the entry time
// reset is synchronous; the entry table comes up inactive
// results cannot be stalled; busy drops in the cycle the last result is shown
module weekly_alarm_timer_table_top
  import watt_pkg::*;
#(
  parameter int TIMER_ENTRIES = TimerEntries
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic [1:0]  func,
  input  logic [3:0]  entry_index,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  input  logic [2:0]  weekday,
  input  logic [7:0]  day_mask,
  input  logic [7:0]  mode_mask,
  input  logic        is_action,
  input  logic [15:0] act_code,
  input  logic [15:0] act_arg_one,
  input  logic [31:0] act_arg_two,
  output logic        valid,
  output logic [1:0]  result_kind,
  output logic        error,
  output logic        out_is_action,
  output logic [15:0] out_act_code,
  output logic [15:0] out_arg_one,
  output logic [31:0] out_arg_two,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [7:0]  out_day_mask,
  output logic [7:0]  out_mode_mask,
  output logic        last
);
  localparam int IW = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;

  // configuration
  logic [2:0]  box_mode;
  logic [7:0]  dev_mask;
  always_ff @(posedge clk) begin
    if (rst) begin
      box_mode <= '0;
      dev_mask <= 8'hff;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WORK_MODE: box_mode <= cfg_data[2:0];
        REG_DEV_MASK:  dev_mask <= cfg_data[7:0];
        // device number has no effect on any result
        REG_DEV_NUM:   ;
        default: ;
      endcase
    end
  end

  // entry table
  logic [TIMER_ENTRIES-1:0] act_v, exp_v;
  logic [TodW-1:0] tod_m [TIMER_ENTRIES];
  logic [7:0]  dm_m [TIMER_ENTRIES];
  logic [7:0]  mm_m [TIMER_ENTRIES];
  logic        ia_m [TIMER_ENTRIES];
  logic [15:0] ac_m [TIMER_ENTRIES];
  logic [15:0] a1_m [TIMER_ENTRIES];
  logic [31:0] a2_m [TIMER_ENTRIES];
  logic [TodW-1:0] prev_sod;

  // latched command
  state_t state, state_next;
  func_t  cfunc;
  logic [3:0] cidx;
  logic [2:0] cwd;
  logic [TodW-1:0] now;
  logic [5:0]  cmin, csec;
  logic [7:0]  cdm, cmm;
  logic        cia;
  logic [15:0] cac, ca1;
  logic [31:0] ca2;
  logic [IW:0] scan;
  logic        rollover;

  logic [IW-1:0] si;
  assign si = scan[IW-1:0];
  logic idx_ok;
  assign idx_ok = {1'b0, cidx} < 5'(TIMER_ENTRIES);
  logic [IW-1:0] ci;
  assign ci = cidx[IW-1:0];

  logic dv_go, dv_done;
  logic [4:0] dv_h;
  logic [5:0] dv_m, dv_s;
  watt_divider u_div (
    .clk(clk), .rst(rst), .go(dv_go), .tod(tod_m[ci]),
    .done(dv_done), .hrs(dv_h), .mins(dv_m), .secs(dv_s)
  );

  // shared compare unit: eligibility of the scanned entry
  logic dayb, fire;
  logic [TodW-1:0] diff;
  always_comb begin
    dayb = (cwd <= 3'd6) && dm_m[si][cwd];
    diff = now - tod_m[si];
    fire = act_v[si] && (rollover ? !dayb ? 1'b0 : 1'b1 : !exp_v[si])
      && mm_m[si][box_mode] && dayb && (tod_m[si] <= now) && (diff <= TodW'(5));
  end

  always_comb begin
    state_next = state;
    dv_go = 1'b0;
    case (state)
      ST_IDLE: if (start) state_next = ST_TIME;
      ST_TIME: begin
        if (cfunc == FUNC_TICK) state_next = dev_mask[box_mode] ? ST_SCAN : ST_DONE;
        else if (cfunc == FUNC_READ && idx_ok && act_v[ci]) begin
          state_next = ST_SPLIT;
          dv_go = 1'b1;
        end else state_next = ST_DONE;
      end
      ST_SCAN: if (scan == (IW+1)'(TIMER_ENTRIES - 1)) state_next = ST_DONE;
      ST_SPLIT: if (dv_done) state_next = ST_IDLE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath and results
  always_ff @(posedge clk) begin
    if (rst) begin
      act_v <= '0;
      exp_v <= '0;
      prev_sod <= '0;
      valid <= 1'b0;
      scan <= '0;
      rollover <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: if (start) begin
          cfunc <= func_t'(func); cidx <= entry_index; cwd <= weekday;
          cmin <= minute; csec <= second;
          cdm <= day_mask; cmm <= mode_mask; cia <= is_action;
          cac <= act_code; ca1 <= act_arg_one; ca2 <= act_arg_two;
          now <= TodW'(hour) * TodW'(3600);
        end
        ST_TIME: begin
          scan <= '0;
          error <= 1'b0;
          if (cfunc == FUNC_TICK) begin
            rollover <= (now + TodW'(cmin) * TodW'(60) + TodW'(csec) < prev_sod)
              && (now + TodW'(cmin) * TodW'(60) + TodW'(csec) < TodW'(10));
            now <= now + TodW'(cmin) * TodW'(60) + TodW'(csec);
            prev_sod <= now + TodW'(cmin) * TodW'(60) + TodW'(csec);
            if (!dev_mask[box_mode] && now + TodW'(cmin) * TodW'(60) + TodW'(csec)
                < prev_sod && now + TodW'(cmin) * TodW'(60) + TodW'(csec) < TodW'(10)) begin
              for (int k = 0; k < TIMER_ENTRIES; k++)
                if (act_v[k]) exp_v[k] <= !((cwd <= 3'd6) && dm_m[k][cwd]);
            end
          end else if (!idx_ok) begin
            error <= 1'b1;
          end else if (cfunc == FUNC_SET) begin
            tod_m[ci] <= now + TodW'(cmin) * TodW'(60) + TodW'(csec);
            dm_m[ci] <= cdm; mm_m[ci] <= cmm; ia_m[ci] <= cia;
            ac_m[ci] <= cac; a1_m[ci] <= ca1; a2_m[ci] <= ca2;
            act_v[ci] <= 1'b1; exp_v[ci] <= 1'b0;
          end else if (!act_v[ci]) begin
            error <= 1'b1;
          end else if (cfunc == FUNC_DEL) begin
            act_v[ci] <= 1'b0; exp_v[ci] <= 1'b0;
          end
        end
        ST_SCAN: begin
          scan <= scan + 1'b1;
          if (rollover && act_v[si]) exp_v[si] <= !dayb;
          if (fire) begin
            valid <= 1'b1; result_kind <= KIND_FIRE; last <= 1'b0;
            out_is_action <= ia_m[si]; out_act_code <= ac_m[si];
            out_arg_one <= a1_m[si]; out_arg_two <= ia_m[si] ? a2_m[si] : '0;
            out_hour <= '0; out_minute <= '0; out_second <= '0;
            out_day_mask <= '0; out_mode_mask <= '0;
            if (dm_m[si][7]) begin
              act_v[si] <= 1'b0; exp_v[si] <= 1'b0;
            end else exp_v[si] <= 1'b1;
          end
        end
        ST_SPLIT: if (dv_done) begin
          valid <= 1'b1; result_kind <= KIND_READ; last <= 1'b1;
          out_is_action <= ia_m[ci]; out_act_code <= ac_m[ci];
          out_arg_one <= a1_m[ci]; out_arg_two <= ia_m[ci] ? a2_m[ci] : '0;
          out_hour <= dv_h; out_minute <= dv_m; out_second <= dv_s;
          out_day_mask <= dm_m[ci]; out_mode_mask <= mm_m[ci];
        end
        ST_DONE: begin
          valid <= 1'b1; result_kind <= KIND_DONE; last <= 1'b1;
          out_is_action <= 1'b0; out_act_code <= '0; out_arg_one <= '0;
          out_arg_two <= '0; out_hour <= '0; out_minute <= '0; out_second <= '0;
          out_day_mask <= '0; out_mode_mask <= '0;
        end
        default: ;
      endcase
    end
  end

  // checks
  a_fire_no_err: assert property (@(posedge clk) disable iff (rst)
    valid && result_kind == KIND_FIRE |-> !error && !last) else $error("fire");
  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    valid && last |-> $past(busy)) else $error("stray");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !$past(busy) |-> !valid) else $error("idle");
endmodule

/* tb/tb_weekly_alarm_timer_table_top.sv */
`timescale 1ns / 1ps
module tb_weekly_alarm_timer_table_top;
  import watt_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  entry_index;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [7:0]  day_mask;
    logic [7:0]  mode_mask;
    logic        is_action;
    logic [15:0] act_code;
    logic [15:0] act_arg_one;
    logic [31:0] act_arg_two;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic        error;
    logic        out_is_action;
    logic [15:0] out_act_code;
    logic [15:0] out_arg_one;
    logic [31:0] out_arg_two;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [7:0]  out_day_mask;
    logic [7:0]  out_mode_mask;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        active;
    logic        expired;
    logic [16:0] tod;
    logic [7:0]  dmask;
    logic [7:0]  mmask;
    logic        is_act;
    logic [15:0] code;
    logic [15:0] one;
    logic [31:0] two;
  } alarm_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;
  cmd_t cmd = '0;
  logic valid;
  res_t res;

  // model state
  alarm_t alarms[TimerEntries];
  logic [2:0] box_mode;
  logic [7:0] dev_mask;
  logic [16:0] prev_sod;

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int fail_count = 0;
  int issued = 0;
  int gap = 0;

  always #5 clk = ~clk;

  weekly_alarm_timer_table_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .func(cmd.func), .entry_index(cmd.entry_index), .hour(cmd.hour),
    .minute(cmd.minute), .second(cmd.second), .weekday(cmd.weekday),
    .day_mask(cmd.day_mask), .mode_mask(cmd.mode_mask), .is_action(cmd.is_action),
    .act_code(cmd.act_code), .act_arg_one(cmd.act_arg_one),
    .act_arg_two(cmd.act_arg_two),
    .valid(valid), .result_kind(res.result_kind), .error(res.error),
    .out_is_action(res.out_is_action), .out_act_code(res.out_act_code),
    .out_arg_one(res.out_arg_one), .out_arg_two(res.out_arg_two),
    .out_hour(res.out_hour), .out_minute(res.out_minute),
    .out_second(res.out_second), .out_day_mask(res.out_day_mask),
    .out_mode_mask(res.out_mode_mask), .last(res.last)
  );

  function automatic logic weekday_hit(logic [7:0] m, logic [2:0] d);
    return (d <= 3'd6) ? m[d] : 1'b0;
  endfunction

  function automatic res_t payload_of(alarm_t a, kind_t k);
    res_t r;
    r = '0;
    r.result_kind = k;
    r.out_is_action = a.is_act;
    r.out_act_code = a.code;
    r.out_arg_one = a.one;
    r.out_arg_two = a.is_act ? a.two : 32'd0;
    return r;
  endfunction

  // work out results of one accepted item and update the table
  task automatic predict_alarms(cmd_t c);
    res_t r;
    logic [16:0] now;
    logic [16:0] t;
    now = c.hour * 17'd3600 + c.minute * 17'd60 + c.second;
    r = '0;
    r.last = 1'b1;
    if (c.func == FUNC_TICK) begin
      if (now < prev_sod && now < 17'd10) begin
        foreach (alarms[i])
          if (alarms[i].active) alarms[i].expired = !weekday_hit(alarms[i].dmask, c.weekday);
      end
      prev_sod = now;
      if (dev_mask[box_mode]) begin
        foreach (alarms[i]) begin
          t = alarms[i].tod;
          if (alarms[i].active && !alarms[i].expired && alarms[i].mmask[box_mode] &&
              weekday_hit(alarms[i].dmask, c.weekday) && t <= now && now - t <= 17'd5) begin
            expected_results.push_back(payload_of(alarms[i], KIND_FIRE));
            if (alarms[i].dmask[7]) alarms[i] = '0;
            else alarms[i].expired = 1'b1;
          end
        end
      end
      expected_results.push_back(r);
    end else if (c.entry_index >= TimerEntries) begin
      r.error = 1'b1;
      expected_results.push_back(r);
    end else if (c.func == FUNC_SET) begin
      alarms[c.entry_index] = '{1'b1, 1'b0, now, c.day_mask, c.mode_mask, c.is_action,
                                c.act_code, c.act_arg_one, c.act_arg_two};
      expected_results.push_back(r);
    end else if (!alarms[c.entry_index].active) begin
      r.error = 1'b1;
      expected_results.push_back(r);
    end else if (c.func == FUNC_DEL) begin
      alarms[c.entry_index] = '0;
      expected_results.push_back(r);
    end else begin
      r = payload_of(alarms[c.entry_index], KIND_READ);
      t = alarms[c.entry_index].tod;
      r.out_hour = 5'(t / 3600);
      r.out_minute = 6'((t % 3600) / 60);
      r.out_second = 6'(t % 60);
      r.out_day_mask = alarms[c.entry_index].dmask;
      r.out_mode_mask = alarms[c.entry_index].mmask;
      r.last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      predict_alarms(cmd);
      issued++;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap == 0 && pending_cmds.size() > 0) begin
        cmd <= pending_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 0) gap--;
      else if (pending_cmds.size() > 0) begin
        cmd <= pending_cmds.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind %0d", res.result_kind);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (res.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, res.result_kind); fail_count++;
        end
        if (res.error !== e.error) begin
          $error("error exp %0d got %0d", e.error, res.error); fail_count++;
        end
        if (res.out_is_action !== e.out_is_action) begin
          $error("out_is_action exp %0d got %0d", e.out_is_action, res.out_is_action);
          fail_count++;
        end
        if (res.out_act_code !== e.out_act_code) begin
          $error("out_act_code exp %0h got %0h", e.out_act_code, res.out_act_code);
          fail_count++;
        end
        if (res.out_arg_one !== e.out_arg_one) begin
          $error("out_arg_one exp %0h got %0h", e.out_arg_one, res.out_arg_one); fail_count++;
        end
        if (res.out_arg_two !== e.out_arg_two) begin
          $error("out_arg_two exp %0h got %0h", e.out_arg_two, res.out_arg_two); fail_count++;
        end
        if (res.out_hour !== e.out_hour) begin
          $error("out_hour exp %0d got %0d", e.out_hour, res.out_hour); fail_count++;
        end
        if (res.out_minute !== e.out_minute) begin
          $error("out_minute exp %0d got %0d", e.out_minute, res.out_minute); fail_count++;
        end
        if (res.out_second !== e.out_second) begin
          $error("out_second exp %0d got %0d", e.out_second, res.out_second); fail_count++;
        end
        if (res.out_day_mask !== e.out_day_mask) begin
          $error("out_day_mask exp %0h got %0h", e.out_day_mask, res.out_day_mask);
          fail_count++;
        end
        if (res.out_mode_mask !== e.out_mode_mask) begin
          $error("out_mode_mask exp %0h got %0h", e.out_mode_mask, res.out_mode_mask);
          fail_count++;
        end
        if (res.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, res.last); fail_count++;
        end
      end
    end
  end

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c = '0;
    c.func = 2'($urandom_range(0, 3));
    c.entry_index = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(8, 15)
                                                    : $urandom_range(0, 7));
    c.hour = 5'($urandom_range(0, 23));
    c.minute = 6'($urandom_range(0, 59));
    c.second = 6'($urandom_range(0, 59));
    c.weekday = 3'(($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6));
    c.day_mask = 8'($urandom);
    c.mode_mask = 8'(($urandom_range(0, 2) == 0) ? $urandom : 32'hff);
    c.is_action = 1'($urandom);
    c.act_code = 16'($urandom);
    c.act_arg_one = 16'($urandom);
    c.act_arg_two = $urandom;
    return c;
  endfunction

  function automatic cmd_t make_cmd(int f, int idx, int h, int m, int s, int wd, int dm);
    cmd_t c;
    c = rand_cmd();
    c.func = 2'(f); c.entry_index = 4'(idx); c.hour = 5'(h); c.minute = 6'(m);
    c.second = 6'(s); c.weekday = 3'(wd); c.day_mask = 8'(dm); c.mode_mask = 8'hff;
    return c;
  endfunction

  task automatic write_reg(logic [1:0] a, logic [15:0] d);
    cfg_we <= 1'b1; cfg_addr <= a; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == REG_WORK_MODE) box_mode = d[2:0];
    else if (a == REG_DEV_MASK) dev_mask = d[7:0];
  endtask

  // wait for all items and results, then let the block settle
  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // one scenario: alarm set near a time, then ticks walking across it
  task automatic queue_scenario();
    cmd_t c;
    logic [3:0] idx;
    logic [4:0] h;
    logic [5:0] m;
    logic [5:0] s;
    logic [2:0] wd;
    idx = 4'($urandom_range(0, 7));
    h = 5'($urandom_range(0, 23)); m = 6'($urandom_range(0, 59));
    s = 6'($urandom_range(0, 50));
    wd = 3'($urandom_range(0, 6));
    c = rand_cmd(); c.func = FUNC_SET; c.entry_index = idx;
    c.hour = h; c.minute = m; c.second = s;
    if ($urandom_range(0, 3) != 0) c.day_mask[wd] = 1'b1;
    pending_cmds.push_back(c);
    repeat ($urandom_range(1, 3)) begin
      c = make_cmd(FUNC_TICK, 0, h, m, s + $urandom_range(0, 8), wd, 0);
      pending_cmds.push_back(c);
    end
    if ($urandom_range(0, 1)) pending_cmds.push_back(make_cmd(FUNC_READ, idx, 0, 0, 0, 0, 0));
    if ($urandom_range(0, 3) == 0) pending_cmds.push_back(rand_cmd());
  endtask

  initial begin
    foreach (alarms[i]) alarms[i] = '0;
    box_mode = 3'd0; dev_mask = 8'hff; prev_sod = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    write_reg(REG_DEV_NUM, 16'hffff);
    pending_cmds.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_DEL, 1, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 15, 0, 0, 0, 0, 8'hff));
    pending_cmds.push_back(make_cmd(FUNC_READ, 8, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 23, 59, 58, 0, 8'h7f));
    pending_cmds.push_back(make_cmd(FUNC_SET, 7, 0, 0, 2, 0, 8'h81));
    pending_cmds.push_back(make_cmd(FUNC_SET, 3, 31, 63, 63, 0, 8'h00));
    pending_cmds.push_back(make_cmd(FUNC_READ, 3, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_READ, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 23, 59, 59, 6, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 3, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 0, 0, 4, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_READ, 7, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 23, 59, 58, 0, 8'h7f));
    pending_cmds.push_back(make_cmd(FUNC_SET, 0, 12, 0, 0, 0, 8'h7f));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 12, 0, 5, 7, 0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 12, 0, 6, 3, 0));
    pending_cmds.push_back(make_cmd(FUNC_DEL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_DEL, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(FUNC_DEL, 3, 0, 0, 0, 0, 0));
    drain();

    // device mode off: nothing fires
    write_reg(REG_WORK_MODE, 16'd7);
    write_reg(REG_DEV_MASK, 16'h7f);
    pending_cmds.push_back(make_cmd(FUNC_SET, 2, 1, 0, 0, 1, 8'h7f));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 0, 1, 0, 1, 1, 0));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WORK_MODE, 16'((ph == 0) ? 0 : (ph == 1) ? 7 : $urandom_range(0, 7)));
      write_reg(REG_DEV_MASK, 16'((ph == 0) ? 255 : (ph == 1) ? 0 : $urandom_range(0, 255)));
      write_reg(REG_DEV_NUM, 16'((ph == 0) ? 0 : $urandom));
      while (issued < 20 + 16 * (ph + 1)) begin
        if ($urandom_range(0, 4) == 0) pending_cmds.push_back(rand_cmd());
        else queue_scenario();
        while (pending_cmds.size() > 0) @(posedge clk);
      end
      drain();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule

/* weekly_alarm_timer_table_top.f */
hw/rtl/watt_pkg.sv
hw/rtl/watt_divider.sv
hw/rtl/weekly_alarm_timer_table_top.sv
tb/tb_weekly_alarm_timer_table_top.sv
